@@ sv/scd_pkg.sv @@
// Shared constants, stage types and the month start table for the serial day decoder.
package scd_pkg;

   localparam int SERIAL_W = 23;
   localparam int OFFSET_W = 20;
   localparam int YEAR_W = 14;
   localparam int MONTH_W = 4;
   localparam int MDAY_W = 5;
   localparam int WDAY_W = 3;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd693594;

   localparam int DAYS_400Y = 146097;
   localparam int DAYS_100Y = 36524;
   localparam int DAYS_4Y = 1461;
   localparam int DAYS_1Y = 365;
   localparam int DAYS_1W = 7;
   localparam int LAST_DAY = 3652059;
   localparam int YEARS_400 = 400;
   localparam int YEARS_100 = 100;
   localparam int YEARS_4 = 4;
   localparam int LAST_Q100 = 3;
   localparam int LAST_Q1 = 3;
   localparam int LAST_Q4 = DAYS_100Y / DAYS_4Y;
   localparam int MONTHS = 12;

   // Sum of serial and offset, and the day count range of valid dates.
   localparam int T_W = 24;
   localparam int DAY_W = 22;

   // Reciprocal multipliers: the estimate is the true quotient or one less.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_400Y = (1 << RECIP_SHIFT) / DAYS_400Y;
   localparam int RECIP_4Y = (1 << RECIP_SHIFT) / DAYS_4Y;
   localparam int RECIP_WEEK = (1 << RECIP_SHIFT) / DAYS_1W;

   localparam int Q400_W = 5;
   localparam int R400_W = 18;
   localparam int R100_W = 16;
   localparam int Q4_W = 5;
   localparam int R4_W = 11;
   localparam int YDAY_W = 9;
   localparam int Q7_W = 20;

   typedef struct packed {
      logic                ok;
      logic [DAY_W-1:0]    count;
      logic [DAY_W-1:0]    day;
      logic [Q400_W-1:0]   q400_est;
      logic [Q7_W-1:0]     q7_est;
   } stage1_type;

   typedef struct packed {
      logic                ok;
      logic [Q400_W-1:0]   q400;
      logic [R400_W-1:0]   r400;
      logic [WDAY_W-1:0]   wday;
   } stage2_type;

   typedef struct packed {
      logic                ok;
      logic [Q400_W-1:0]   q400;
      logic [1:0]          q100;
      logic [R100_W-1:0]   r100;
      logic [WDAY_W-1:0]   wday;
   } stage3_type;

   typedef struct packed {
      logic                ok;
      logic [Q400_W-1:0]   q400;
      logic [1:0]          q100;
      logic [R100_W-1:0]   r100;
      logic [Q4_W-1:0]     q4_est;
      logic [WDAY_W-1:0]   wday;
   } stage4_type;

   typedef struct packed {
      logic                ok;
      logic [Q400_W-1:0]   q400;
      logic [1:0]          q100;
      logic [Q4_W-1:0]     q4;
      logic [R4_W-1:0]     r4;
      logic [WDAY_W-1:0]   wday;
   } stage5_type;

   typedef struct packed {
      logic                ok;
      logic [YEAR_W-1:0]   year;
      logic                leap;
      logic [YDAY_W-1:0]   yday;
      logic [WDAY_W-1:0]   wday;
   } stage6_type;

   // Day of year, from zero, on which month m (from zero) starts.
   function automatic logic [YDAY_W-1:0] month_start(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
      logic [YDAY_W-1:0] base;
      case (m)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

@@ sv/scd_ifs.sv @@
// Request and response channel interfaces of the serial day decoder.
interface scd_req_if;
   logic                            valid;
   logic                            ready;
   logic [scd_pkg::SERIAL_W-1:0]    serial_day;

   modport source (output valid, output serial_day, input ready);
   modport sink (input valid, input serial_day, output ready);
endinterface

interface scd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [scd_pkg::YEAR_W-1:0]      year;
   logic [scd_pkg::MONTH_W-1:0]     month;
   logic [scd_pkg::MDAY_W-1:0]      day_of_month;
   logic [scd_pkg::WDAY_W-1:0]      weekday;
   logic                            leap_year;
   logic                            valid_res;

   modport source (output valid, output year, output month, output day_of_month,
                   output weekday, output leap_year, output valid_res, input ready);
   modport sink (input valid, input year, input month, input day_of_month,
                 input weekday, input leap_year, input valid_res, output ready);
endinterface

@@ sv/scd_pipe.sv @@
// Six-stage pipeline from serial day to year, day of year, weekday and leap flag.
module scd_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [scd_pkg::SERIAL_W-1:0]    serial_day,
   input  logic [scd_pkg::OFFSET_W-1:0]    day_offset,
   output logic                            out_valid,
   output scd_pkg::stage6_type             out_stage
);

   localparam int PROD_W = scd_pkg::DAY_W + scd_pkg::RECIP_SHIFT;
   localparam int PROD4_W = scd_pkg::R100_W + scd_pkg::RECIP_SHIFT;

   logic [5:0] vld_ff, vld_in;

   scd_pkg::stage1_type s1_ff, s1_in;
   scd_pkg::stage2_type s2_ff, s2_in;
   scd_pkg::stage3_type s3_ff, s3_in;
   scd_pkg::stage4_type s4_ff, s4_in;
   scd_pkg::stage5_type s5_ff, s5_in;
   scd_pkg::stage6_type s6_ff, s6_in;

   logic [scd_pkg::T_W-1:0]    t_sum;
   logic [PROD_W-1:0]          prod400;
   logic [PROD_W-1:0]          prod7;
   logic [scd_pkg::DAY_W-1:0]  r400_raw;
   logic [scd_pkg::DAY_W-1:0]  r7_raw;
   logic [scd_pkg::R400_W-1:0] r100_raw;
   logic [PROD4_W-1:0]         prod4;
   logic [scd_pkg::R100_W-1:0] r4_raw;
   logic [scd_pkg::R4_W-1:0]   yday_raw;
   logic [1:0]                 q1;

   assign vld_in = {vld_ff[4:0], in_valid};

   // Stage 1: day count, range check and reciprocal quotient estimates.
   always_comb begin
      t_sum = {serial_day[scd_pkg::SERIAL_W-1], serial_day}
            + {{(scd_pkg::T_W - scd_pkg::OFFSET_W){1'b0}}, day_offset};
      s1_in.ok = !t_sum[scd_pkg::T_W-1] && (t_sum != '0)
               && (t_sum <= scd_pkg::T_W'(scd_pkg::LAST_DAY));
      s1_in.count = t_sum[scd_pkg::DAY_W-1:0];
      s1_in.day = s1_in.count - scd_pkg::DAY_W'(1);
      prod400 = PROD_W'(s1_in.day) * PROD_W'(scd_pkg::RECIP_400Y);
      prod7 = PROD_W'(s1_in.count) * PROD_W'(scd_pkg::RECIP_WEEK);
      s1_in.q400_est = prod400[scd_pkg::RECIP_SHIFT +: scd_pkg::Q400_W];
      s1_in.q7_est = prod7[scd_pkg::RECIP_SHIFT +: scd_pkg::Q7_W];
   end

   // Stage 2: correct the 400-year quotient and the weekday remainder.
   always_comb begin
      s2_in.ok = s1_ff.ok;
      r400_raw = s1_ff.day
               - scd_pkg::DAY_W'(s1_ff.q400_est) * scd_pkg::DAY_W'(scd_pkg::DAYS_400Y);
      s2_in.q400 = s1_ff.q400_est;
      if (r400_raw >= scd_pkg::DAY_W'(scd_pkg::DAYS_400Y)) begin
         r400_raw = r400_raw - scd_pkg::DAY_W'(scd_pkg::DAYS_400Y);
         s2_in.q400 = s1_ff.q400_est + scd_pkg::Q400_W'(1);
      end
      s2_in.r400 = r400_raw[scd_pkg::R400_W-1:0];
      r7_raw = s1_ff.count
             - scd_pkg::DAY_W'(s1_ff.q7_est) * scd_pkg::DAY_W'(scd_pkg::DAYS_1W);
      if (r7_raw >= scd_pkg::DAY_W'(scd_pkg::DAYS_1W)) begin
         r7_raw = r7_raw - scd_pkg::DAY_W'(scd_pkg::DAYS_1W);
      end
      s2_in.wday = r7_raw[scd_pkg::WDAY_W-1:0] + scd_pkg::WDAY_W'(1);
   end

   // Stage 3: century within the 400-year cycle; the last day of the cycle
   // stays in the fourth century.
   always_comb begin
      s3_in.ok = s2_ff.ok;
      s3_in.q400 = s2_ff.q400;
      s3_in.wday = s2_ff.wday;
      if (s2_ff.r400 >= scd_pkg::R400_W'(3 * scd_pkg::DAYS_100Y)) begin
         s3_in.q100 = 2'd3;
      end else if (s2_ff.r400 >= scd_pkg::R400_W'(2 * scd_pkg::DAYS_100Y)) begin
         s3_in.q100 = 2'd2;
      end else if (s2_ff.r400 >= scd_pkg::R400_W'(scd_pkg::DAYS_100Y)) begin
         s3_in.q100 = 2'd1;
      end else begin
         s3_in.q100 = 2'd0;
      end
      r100_raw = s2_ff.r400
               - scd_pkg::R400_W'(s3_in.q100) * scd_pkg::R400_W'(scd_pkg::DAYS_100Y);
      s3_in.r100 = r100_raw[scd_pkg::R100_W-1:0];
   end

   // Stage 4: estimate of the 4-year block within the century.
   always_comb begin
      s4_in.ok = s3_ff.ok;
      s4_in.q400 = s3_ff.q400;
      s4_in.q100 = s3_ff.q100;
      s4_in.r100 = s3_ff.r100;
      s4_in.wday = s3_ff.wday;
      prod4 = PROD4_W'(s3_ff.r100) * PROD4_W'(scd_pkg::RECIP_4Y);
      s4_in.q4_est = prod4[scd_pkg::RECIP_SHIFT +: scd_pkg::Q4_W];
   end

   // Stage 5: correct the 4-year quotient.
   always_comb begin
      s5_in.ok = s4_ff.ok;
      s5_in.q400 = s4_ff.q400;
      s5_in.q100 = s4_ff.q100;
      s5_in.wday = s4_ff.wday;
      r4_raw = s4_ff.r100
             - scd_pkg::R100_W'(s4_ff.q4_est) * scd_pkg::R100_W'(scd_pkg::DAYS_4Y);
      s5_in.q4 = s4_ff.q4_est;
      if (r4_raw >= scd_pkg::R100_W'(scd_pkg::DAYS_4Y)) begin
         r4_raw = r4_raw - scd_pkg::R100_W'(scd_pkg::DAYS_4Y);
         s5_in.q4 = s4_ff.q4_est + scd_pkg::Q4_W'(1);
      end
      s5_in.r4 = r4_raw[scd_pkg::R4_W-1:0];
   end

   // Stage 6: year within the 4-year block, the year itself and the leap flag.
   // The year is a leap year when it ends a 4-year block, unless that block
   // ends a century that is not the last of its 400-year cycle.
   always_comb begin
      s6_in.ok = s5_ff.ok;
      s6_in.wday = s5_ff.wday;
      if (s5_ff.r4 >= scd_pkg::R4_W'(3 * scd_pkg::DAYS_1Y)) begin
         q1 = 2'd3;
      end else if (s5_ff.r4 >= scd_pkg::R4_W'(2 * scd_pkg::DAYS_1Y)) begin
         q1 = 2'd2;
      end else if (s5_ff.r4 >= scd_pkg::R4_W'(scd_pkg::DAYS_1Y)) begin
         q1 = 2'd1;
      end else begin
         q1 = 2'd0;
      end
      yday_raw = s5_ff.r4 - scd_pkg::R4_W'(q1) * scd_pkg::R4_W'(scd_pkg::DAYS_1Y);
      s6_in.yday = yday_raw[scd_pkg::YDAY_W-1:0];
      s6_in.year = scd_pkg::YEAR_W'(1)
                 + scd_pkg::YEAR_W'(s5_ff.q400) * scd_pkg::YEAR_W'(scd_pkg::YEARS_400)
                 + scd_pkg::YEAR_W'(s5_ff.q100) * scd_pkg::YEAR_W'(scd_pkg::YEARS_100)
                 + scd_pkg::YEAR_W'(s5_ff.q4) * scd_pkg::YEAR_W'(scd_pkg::YEARS_4)
                 + scd_pkg::YEAR_W'(q1);
      s6_in.leap = (q1 == 2'(scd_pkg::LAST_Q1))
                 && ((s5_ff.q4 != scd_pkg::Q4_W'(scd_pkg::LAST_Q4))
                     || (s5_ff.q100 == 2'(scd_pkg::LAST_Q100)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_stage = s6_ff;

endmodule

@@ sv/serial_day_to_calendar_date.sv @@
// Top level of the serial day to Gregorian calendar date decoder.
//
//   channel  direction  words carried
//   req      in         serial_day (23-bit two's complement)
//   rsp      out        year, month, day_of_month, weekday, leap_year, valid_res
//   csr      in         day_offset (20 bits, write only)
//
// The edge that accepts a word loads the first of six pipeline stages (the 400-year
// and 4-year reciprocal divides each take two); the word then passes through the
// stages in order and into the output register that decodes the month and drives rsp.valid.
// A new word is accepted every cycle while rsp is not stalled.
// Reset is synchronous and clears all valid bits; day_offset returns to 693594.
// When rsp stalls with a word waiting, the whole pipeline holds in place.
module serial_day_to_calendar_date (
   input  logic                            clock,
   input  logic                            reset,
   scd_req_if.sink                         req,
   scd_rsp_if.source                       rsp,
   input  logic                            csr_wr_en,
   input  logic [scd_pkg::OFFSET_W-1:0]    csr_wr_data
);

   logic [scd_pkg::OFFSET_W-1:0] offset_ff;
   logic                         advance;
   logic                         pipe_valid;
   scd_pkg::stage6_type          pipe_stage;

   logic                           rsp_valid_ff;
   logic [scd_pkg::YEAR_W-1:0]     year_ff, year_in;
   logic [scd_pkg::MONTH_W-1:0]    month_ff, month_in;
   logic [scd_pkg::MDAY_W-1:0]     mday_ff, mday_in;
   logic [scd_pkg::WDAY_W-1:0]     wday_ff, wday_in;
   logic                           leap_ff, leap_in;
   logic                           ok_ff, ok_in;

   logic [scd_pkg::MONTH_W-1:0]    m_idx;
   logic [scd_pkg::YDAY_W-1:0]     mday_full;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= scd_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   scd_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req.valid),
      .serial_day (req.serial_day),
      .day_offset (offset_ff),
      .out_valid  (pipe_valid),
      .out_stage  (pipe_stage)
   );

   // Month is the count of month starts at or below the day of year.
   always_comb begin
      m_idx = '0;
      for (int k = 1; k < scd_pkg::MONTHS; k++) begin
         if (pipe_stage.yday >= scd_pkg::month_start(pipe_stage.leap,
                                                     scd_pkg::MONTH_W'(k))) begin
            m_idx = scd_pkg::MONTH_W'(k);
         end
      end
      mday_full = pipe_stage.yday - scd_pkg::month_start(pipe_stage.leap, m_idx)
                + scd_pkg::YDAY_W'(1);
      ok_in = pipe_stage.ok;
      if (pipe_stage.ok) begin
         year_in = pipe_stage.year;
         month_in = m_idx + scd_pkg::MONTH_W'(1);
         mday_in = mday_full[scd_pkg::MDAY_W-1:0];
         wday_in = pipe_stage.wday;
         leap_in = pipe_stage.leap;
      end else begin
         year_in = '0;
         month_in = '0;
         mday_in = '0;
         wday_in = '0;
         leap_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         year_ff <= year_in;
         month_ff <= month_in;
         mday_ff <= mday_in;
         wday_ff <= wday_in;
         leap_ff <= leap_in;
         ok_ff <= ok_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.year = year_ff;
   assign rsp.month = month_ff;
   assign rsp.day_of_month = mday_ff;
   assign rsp.weekday = wday_ff;
   assign rsp.leap_year = leap_ff;
   assign rsp.valid_res = ok_ff;

endmodule
